// ===== hdl/pdlw_pkg.sv =====
// Package for the polled device link watchdog.
// Shared types, command codes and constants; no dependencies.
package pdlw_pkg;

  // Fixed field widths
  localparam int unsigned ID_W      = 16;
  localparam int unsigned CTR_W     = 10;
  localparam int unsigned MASK_W    = 16;
  localparam int unsigned IDX_OUT_W = 4;
  localparam int unsigned CFG_DW    = 5;

  localparam int unsigned FIXED_ENTRIES = 10;

  localparam logic signed [CTR_W-1:0] RELOAD_VALUE = 10'sd6;
  localparam logic signed [CTR_W-1:0] AGE_FLOOR    = -10'sd256;

  typedef enum logic [1:0] {
    CMD_POLL   = 2'd0,
    CMD_REPLY  = 2'd1,
    CMD_SWITCH = 2'd2,
    CMD_LOAD   = 2'd3
  } cmd_e;

  typedef enum logic {
    CFG_DEVICE_COUNT = 1'b0,
    CFG_FIXED_TEN    = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_e;

  // Per-entry control handed to the entry unit
  typedef struct packed {
    cmd_e cmd;
    logic fixed_mode;
    logic poll;       // item issued a poll
    logic is_ptr;     // entry is the polled one
    logic in_count;   // entry below device count
    logic in_fixed;   // entry among the first ten
  } entry_ctl_t;

endpackage

// ===== hdl/pdlw_id_ram.sv =====
// Device ID store: one write port, one registered read port.
// Depends on nothing but its parameters.
module pdlw_id_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned DW    = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/pdlw_entry_alu.sv =====
// Shared entry unit: ID compare, counter reload/age, switch update.
// Uses pdlw_pkg types and constants.
module pdlw_entry_alu (
  input  pdlw_pkg::entry_ctl_t           ctl_i,
  input  logic [pdlw_pkg::ID_W-1:0]      entry_id_i,
  input  logic [pdlw_pkg::ID_W-1:0]      dev_id_i,
  input  logic                           switch_value_i,
  input  logic signed [pdlw_pkg::CTR_W-1:0] ctr_i,
  input  logic                           sw_i,
  output logic signed [pdlw_pkg::CTR_W-1:0] ctr_o,
  output logic                           sw_o,
  output logic                           alive_o
);

  logic id_hit;
  logic do_age;

  assign id_hit = ctl_i.in_count && (entry_id_i == dev_id_i);

  always_comb begin
    ctr_o  = ctr_i;
    sw_o   = sw_i;
    do_age = 1'b0;
    unique case (ctl_i.cmd)
      pdlw_pkg::CMD_POLL: begin
        if (ctl_i.poll) begin
          do_age = ctl_i.fixed_mode ? ctl_i.in_fixed : (ctl_i.is_ptr && ctl_i.in_count);
        end
        // counters never exceed the reload value, so only the floor gates aging
        if (do_age && (ctr_i > pdlw_pkg::AGE_FLOOR)) begin
          ctr_o = ctr_i - 10'sd1;
        end
      end
      pdlw_pkg::CMD_REPLY: begin
        if (ctl_i.fixed_mode ? ctl_i.in_fixed : id_hit) begin
          ctr_o = pdlw_pkg::RELOAD_VALUE;
        end
      end
      pdlw_pkg::CMD_SWITCH: begin
        if (id_hit) begin
          sw_o = switch_value_i;
        end
      end
      pdlw_pkg::CMD_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  assign alive_o = !ctr_o[pdlw_pkg::CTR_W-1];

endmodule

// ===== hdl/polled_device_link_watchdog.sv =====
// Polled device link watchdog, top level.
// Uses pdlw_pkg, pdlw_id_ram and pdlw_entry_alu.
//
// Usage:
//   Input channel s_axis_*: one item per command. tuser carries the command
//   (poll tick, link reply, switch report, load ID); tdata carries the
//   device ID, the table entry, the switch value and the poll enable.
//   Output channel m_axis_*: exactly one result item per input item, with
//   the poll flag in tuser and poll index, poll target, alive mask and
//   switch mask in tdata. Masks show the table after the item's update.
//   Config port: cfg_we_i writes device_count (index 0) or fixed_ten_mode
//   (index 1); write only while no item is in flight.
// Operation:
//   An accepted item walks every table entry through one shared entry unit,
//   one entry per cycle behind the ID memory's registered read, between the
//   accept and the output-register load; s_axis_tready high only idle.
//   The result sits in an output register; the next item is accepted while it
//   waits, and the walk stalls at its end until the register is free.
// Reset: counters go to 6, switch bits, poll pointer, tick phase and config
//   registers to zero; device IDs are undefined until loaded.
module polled_device_link_watchdog #(
  parameter int unsigned MAX_DEVICES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [4:0]  cfg_data_i,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // dev_id[15:0], entry_index[19:16],
                                     // switch_value[20], poll_enable[21], zero
  input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // poll_index[3:0], poll_target[19:4],
                                     // alive_mask[35:20], switch_mask[51:36], zero
  output logic        m_axis_tuser   // poll_valid
);

  localparam int unsigned PW    = $clog2(MAX_DEVICES);
  localparam int unsigned CNT_W = $clog2(MAX_DEVICES + 1);
  localparam int unsigned CW    = pdlw_pkg::CTR_W;
  localparam int unsigned IW    = pdlw_pkg::ID_W;
  localparam int unsigned MW    = pdlw_pkg::MASK_W;

  // ---------------- configuration ----------------
  logic [4:0] dev_count_q;
  logic       fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_count_q <= '0;
      fixed_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (pdlw_pkg::cfg_idx_e'(cfg_idx_i))
        pdlw_pkg::CFG_DEVICE_COUNT: dev_count_q <= cfg_data_i;
        pdlw_pkg::CFG_FIXED_TEN:    fixed_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // count clamped to the table size
  logic [CNT_W-1:0] eff_cnt;
  assign eff_cnt = (32'(dev_count_q) > MAX_DEVICES) ? CNT_W'(MAX_DEVICES)
                                                    : CNT_W'(dev_count_q);

  // ---------------- input unpack ----------------
  pdlw_pkg::cmd_e  in_cmd;
  logic [IW-1:0]   in_dev_id;
  logic [3:0]      in_entry;
  logic            in_sw;
  logic            in_en;

  assign in_cmd    = pdlw_pkg::cmd_e'(s_axis_tuser);
  assign in_dev_id = s_axis_tdata[15:0];
  assign in_entry  = s_axis_tdata[19:16];
  assign in_sw     = s_axis_tdata[20];
  assign in_en     = s_axis_tdata[21];

  // ---------------- sequencer ----------------
  pdlw_pkg::state_e state_q, state_d;
  logic             accept;
  logic [CNT_W-1:0] walk_q, walk_d;
  logic             ev_valid_q, ev_valid_d;
  logic [PW-1:0]    ev_idx_q;
  logic             out_load;
  logic             out_valid_q;

  assign s_axis_tready = (state_q == pdlw_pkg::ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    walk_d     = walk_q;
    ev_valid_d = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      pdlw_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pdlw_pkg::ST_WALK;
          walk_d  = '0;
        end
      end
      pdlw_pkg::ST_WALK: begin
        if (32'(walk_q) < MAX_DEVICES) begin
          ev_valid_d = 1'b1;
          walk_d     = walk_q + CNT_W'(1);
        end else begin
          // last entry is evaluated this cycle
          state_d = pdlw_pkg::ST_DONE;
        end
      end
      pdlw_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = pdlw_pkg::ST_IDLE;
        end
      end
      default: state_d = pdlw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pdlw_pkg::ST_IDLE;
      walk_q     <= '0;
      ev_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      walk_q     <= walk_d;
      ev_valid_q <= ev_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q <= walk_q[PW-1:0];
  end

  // ---------------- poll pointer ----------------
  logic [PW-1:0]    ptr_q, ptr_d;
  logic             phase_q, phase_d;
  logic [CNT_W-1:0] ptr_next;
  logic             poll_hit;

  always_comb begin
    ptr_d    = ptr_q;
    phase_d  = phase_q;
    poll_hit = 1'b0;
    ptr_next = phase_q ? (CNT_W'(ptr_q) + CNT_W'(1)) : CNT_W'(ptr_q);
    if (accept && (in_cmd == pdlw_pkg::CMD_POLL) && in_en) begin
      phase_d = !phase_q;
      if (ptr_next <= eff_cnt) begin
        poll_hit = 1'b1;
        ptr_d    = (ptr_next == eff_cnt) ? '0 : ptr_next[PW-1:0];
      end else begin
        // count was lowered: keep counting up to the table size
        ptr_d = (32'(ptr_next) < MAX_DEVICES) ? ptr_next[PW-1:0] : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= '0;
      phase_q <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      phase_q <= phase_d;
    end
  end

  // ---------------- item registers ----------------
  pdlw_pkg::cmd_e cmd_q;
  logic [IW-1:0]  dev_id_q;
  logic           sw_val_q;
  logic           pv_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_cmd;
      dev_id_q <= in_dev_id;
      sw_val_q <= in_sw;
      pv_q     <= poll_hit;
    end
  end

  // ---------------- ID memory ----------------
  logic          id_we;
  logic [PW-1:0] id_raddr;
  logic [IW-1:0] id_rdata;

  assign id_we    = accept && (in_cmd == pdlw_pkg::CMD_LOAD) &&
                    (32'(in_entry) < MAX_DEVICES);
  assign id_raddr = (32'(walk_q) < MAX_DEVICES) ? walk_q[PW-1:0] : '0;

  pdlw_id_ram #(
    .DEPTH (MAX_DEVICES),
    .AW    (PW),
    .DW    (IW)
  ) u_id_ram (
    .clk_i   (clk_i),
    .we_i    (id_we),
    .waddr_i (PW'(in_entry)),
    .wdata_i (in_dev_id),
    .raddr_i (id_raddr),
    .rdata_o (id_rdata)
  );

  // ---------------- counters and switch bits ----------------
  logic signed [CW-1:0] ctr_q [MAX_DEVICES];
  logic                 swb_q [MAX_DEVICES];

  pdlw_pkg::entry_ctl_t ctl;
  logic signed [CW-1:0] ctr_new;
  logic                 sw_new;
  logic                 alive_new;

  always_comb begin
    ctl.cmd        = cmd_q;
    ctl.fixed_mode = fixed_q;
    ctl.poll       = pv_q;
    ctl.is_ptr     = (ev_idx_q == ptr_q);
    ctl.in_count   = (CNT_W'(ev_idx_q) < eff_cnt);
    ctl.in_fixed   = (32'(ev_idx_q) < pdlw_pkg::FIXED_ENTRIES);
  end

  pdlw_entry_alu u_alu (
    .ctl_i          (ctl),
    .entry_id_i     (id_rdata),
    .dev_id_i       (dev_id_q),
    .switch_value_i (sw_val_q),
    .ctr_i          (ctr_q[ev_idx_q]),
    .sw_i           (swb_q[ev_idx_q]),
    .ctr_o          (ctr_new),
    .sw_o           (sw_new),
    .alive_o        (alive_new)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DEVICES; i++) begin
        ctr_q[i] <= pdlw_pkg::RELOAD_VALUE;
        swb_q[i] <= 1'b0;
      end
    end else if (ev_valid_q) begin
      ctr_q[ev_idx_q] <= ctr_new;
      swb_q[ev_idx_q] <= sw_new;
    end
  end

  // ---------------- result accumulation ----------------
  logic [MW-1:0] alive_acc_q;
  logic [MW-1:0] sw_acc_q;
  logic [IW-1:0] target_q;
  logic          in_mask;

  assign in_mask = ctl.in_count && (32'(ev_idx_q) < MW);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      alive_acc_q <= '0;
      sw_acc_q    <= '0;
      target_q    <= '0;
    end else if (ev_valid_q) begin
      if (in_mask) begin
        alive_acc_q[ev_idx_q[3:0]] <= alive_new;
        sw_acc_q[ev_idx_q[3:0]]    <= sw_new;
      end
      if (pv_q && ctl.is_ptr) begin
        target_q <= id_rdata;
      end
    end
  end

  // ---------------- output register ----------------
  logic [55:0] out_data_q;
  logic        out_pv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_pv_q   <= pv_q;
      out_data_q <= {4'b0, sw_acc_q, alive_acc_q, target_q,
                     pv_q ? ptr_q[3:0] : 4'b0};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_pv_q;

endmodule

// ===== hdl/pdlw_checker.sv =====
// Port-level checks for the polled device link watchdog.
// Bound to polled_device_link_watchdog; no package use.
module pdlw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight: busy right after an accept
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted a second item during a walk");

  // no poll means zero index and target
  a_no_poll_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[19:0] == 20'd0)
    else $error("poll fields set without poll");

endmodule

bind polled_device_link_watchdog pdlw_checker u_pdlw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for polled_device_link_watchdog.
// Depends on pdlw_pkg and the block's RTL; needs no files or arguments.
module tb;

  localparam int unsigned DEVICES      = 16;  // table depth the DUT is built with
  localparam int unsigned DRAIN_CYCLES = 25;  // longer than one walk, as margin
  localparam int unsigned CW           = pdlw_pkg::CTR_W;

  // One command item as the sender sees it
  typedef struct packed {
    pdlw_pkg::cmd_e cmd;
    logic           poll_en;
    logic           sw_value;
    logic [3:0]     entry;
    logic [15:0]    dev_id;
  } dev_cmd_t;

  // One status item as the block reports it
  typedef struct packed {
    logic        poll_valid;
    logic [3:0]  poll_index;
    logic [15:0] poll_target;
    logic [15:0] alive_mask;
    logic [15:0] switch_mask;
  } link_status_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input has a known value from time zero
  // ---------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_idx_i     = 1'b0;
  logic [4:0]  cfg_data_i    = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;  // dev_id[15:0], entry_index[19:16],
                                    // switch_value[20], poll_enable[21], zero
  logic [1:0]  s_axis_tuser  = '0;  // cmd[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // poll_index[3:0], poll_target[19:4],
                                    // alive_mask[35:20], switch_mask[51:36], zero
  logic        m_axis_tuser;        // poll_valid

  always #6 clk_i = ~clk_i;

  polled_device_link_watchdog #(
    .MAX_DEVICES(DEVICES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // ---------------------------------------------------------------------------
  // Shadow of the device table, updated when an item is accepted
  // ---------------------------------------------------------------------------
  logic [15:0]          dev_ids  [DEVICES];
  logic signed [CW-1:0] link_ctr [DEVICES];
  logic                 sw_bits  [DEVICES];
  int unsigned          poll_ptr;
  logic                 tick_phase;
  logic [4:0]           dev_count;
  logic                 fixed_ten;

  // Traffic bookkeeping
  dev_cmd_t     pending_cmds[$];     // items waiting for the driver
  link_status_t expected_status[$];  // predicted results, oldest first
  dev_cmd_t     cur_cmd;
  int unsigned  in_flight    = 0;    // popped by the driver, result not yet seen
  int unsigned  send_gap     = 0;
  int unsigned  stall_left   = 0;
  bit           no_idle      = 1'b0; // phase runs back to back on both sides
  int unsigned  mismatches   = 0;
  int unsigned  items_queued = 0;
  int unsigned  results_seen = 0;
  int unsigned  polls_issued = 0;
  int unsigned  settings     = 0;
  bit           floor_seen   = 1'b0;

  // Aging: counters already at the floor stay there
  function automatic void age_counter(input int unsigned i);
    if (link_ctr[i] <= pdlw_pkg::RELOAD_VALUE && link_ctr[i] > pdlw_pkg::AGE_FLOOR)
      link_ctr[i] = link_ctr[i] - CW'(1);
    if (link_ctr[i] == pdlw_pkg::AGE_FLOOR) floor_seen = 1'b1;
  endfunction

  // Apply one command to the shadow table and return the status it produces
  function automatic link_status_t step_table(input dev_cmd_t c);
    link_status_t r;
    int unsigned  n;
    int unsigned  nxt;
    r = '0;
    n = (dev_count > DEVICES) ? DEVICES : dev_count;  // counts above depth saturate
    case (c.cmd)
      pdlw_pkg::CMD_POLL: begin
        if (c.poll_en) begin
          // pointer moves only on every second tick
          nxt = poll_ptr;
          if (!tick_phase) begin
            tick_phase = 1'b1;
          end else begin
            tick_phase = 1'b0;
            nxt = poll_ptr + 1;
          end
          if (nxt <= n) begin
            if (nxt >= n) nxt = 0;
            poll_ptr = nxt;
            if (fixed_ten) begin
              for (int i = 0; i < pdlw_pkg::FIXED_ENTRIES; i++) age_counter(i);
            end else if (nxt < n) begin
              age_counter(nxt);  // zero count polls entry 0 but ages nothing
            end
            r.poll_valid  = 1'b1;
            r.poll_index  = 4'(nxt);
            r.poll_target = dev_ids[nxt];
          end else begin
            // pointer stranded above a lowered count keeps running to the top
            poll_ptr = (nxt < DEVICES) ? nxt : 0;
          end
        end
      end
      pdlw_pkg::CMD_REPLY: begin
        if (fixed_ten) begin
          for (int i = 0; i < pdlw_pkg::FIXED_ENTRIES; i++)
            link_ctr[i] = pdlw_pkg::RELOAD_VALUE;
        end else begin
          for (int i = 0; i < n; i++)
            if (dev_ids[i] == c.dev_id) link_ctr[i] = pdlw_pkg::RELOAD_VALUE;
        end
      end
      pdlw_pkg::CMD_SWITCH: begin
        for (int i = 0; i < n; i++)
          if (dev_ids[i] == c.dev_id) sw_bits[i] = c.sw_value;
      end
      default: begin
        dev_ids[c.entry] = c.dev_id;
      end
    endcase
    for (int i = 0; i < n; i++) begin
      r.alive_mask[i]  = (link_ctr[i] >= 0);
      r.switch_mask[i] = sw_bits[i];
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 50)
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued items, predicts each one at its handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drv_proc
    link_status_t res;
    logic         hold;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      hold = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        res = step_table(cur_cmd);
        if (res.poll_valid) polls_issued++;
        expected_status.push_back(res);
        hold = 1'b0;
      end
      if (!hold) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_axis_tdata <= {2'b00, cur_cmd.poll_en, cur_cmd.sw_value,
                           cur_cmd.entry, cur_cmd.dev_id};
          s_axis_tuser <= cur_cmd.cmd;
          in_flight++;
          send_gap = pick_gap();
          hold = 1'b1;
        end
      end
      s_axis_tvalid <= hold;  // single assignment per edge keeps valid steady
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, compares each result with the oldest guess
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : mon_proc
    link_status_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_status.size() == 0) begin
          mismatches++;
          $error("result item with no expectation pending");
        end else begin
          want = expected_status.pop_front();
          check_field("poll_valid",  16'(want.poll_valid), 16'(m_axis_tuser));
          check_field("poll_index",  16'(want.poll_index), 16'(m_axis_tdata[3:0]));
          check_field("poll_target", want.poll_target, m_axis_tdata[19:4]);
          check_field("alive_mask",  want.alive_mask,  m_axis_tdata[35:20]);
          check_field("switch_mask", want.switch_mask, m_axis_tdata[51:36]);
          in_flight--;
          results_seen++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_cmd(input pdlw_pkg::cmd_e cmd, input logic [15:0] id,
                           input logic [3:0] entry, input logic sw, input logic en);
    dev_cmd_t c;
    c.cmd      = cmd;
    c.dev_id   = id;
    c.entry    = entry;
    c.sw_value = sw;
    c.poll_en  = en;
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  // Registers change only with the block idle: queue drained, results all in,
  // then a walk's worth of cycles so nothing is left inside.
  task automatic program_regs(input logic [4:0] count, input logic fixed);
    do @(negedge clk_i); while (in_flight != 0 || pending_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pdlw_pkg::CFG_DEVICE_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    cfg_idx_i  <= pdlw_pkg::CFG_FIXED_TEN;
    cfg_data_i <= {4'b0000, fixed};
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dev_count = count;
    fixed_ten = fixed;
    settings++;
  endtask

  // One register setting and a burst of commands. Replies and switch reports
  // mostly carry IDs from the live part of the table so that they hit.
  task automatic run_phase(input logic [4:0] count, input logic fixed, input int unsigned n,
                           input bit ticks_only);
    dev_cmd_t    c;
    int unsigned live;
    int unsigned roll;
    program_regs(count, fixed);
    no_idle = ($urandom_range(0, 3) == 0);
    live = (count > DEVICES) ? DEVICES : count;
    for (int k = 0; k < n; k++) begin
      c.dev_id   = 16'($urandom_range(0, 16'hFFFF));
      c.entry    = 4'($urandom_range(0, 15));
      c.sw_value = 1'($urandom_range(0, 1));
      c.poll_en  = ticks_only || ($urandom_range(0, 9) != 0);
      roll = $urandom_range(0, 99);
      if (ticks_only || roll < 45) c.cmd = pdlw_pkg::CMD_POLL;
      else if (roll < 70)          c.cmd = pdlw_pkg::CMD_REPLY;
      else if (roll < 90)          c.cmd = pdlw_pkg::CMD_SWITCH;
      else                         c.cmd = pdlw_pkg::CMD_LOAD;
      if ((c.cmd == pdlw_pkg::CMD_REPLY || c.cmd == pdlw_pkg::CMD_SWITCH) && live > 0 &&
          $urandom_range(0, 4) != 0)
        c.dev_id = dev_ids[$urandom_range(0, live - 1)];
      // reloading a known ID makes duplicate entries
      if (c.cmd == pdlw_pkg::CMD_LOAD && $urandom_range(0, 1) == 1)
        c.dev_id = dev_ids[$urandom_range(0, DEVICES - 1)];
      queue_cmd(c.cmd, c.dev_id, c.entry, c.sw_value, c.poll_en);
    end
  endtask

  initial begin : stim_proc
    logic [15:0] load_id;
    // shadow table in its reset state
    for (int i = 0; i < DEVICES; i++) begin
      dev_ids[i]  = '0;
      link_ctr[i] = pdlw_pkg::RELOAD_VALUE;
      sw_bits[i]  = 1'b0;
    end
    poll_ptr   = 0;
    tick_phase = 1'b0;
    dev_count  = '0;
    fixed_ten  = 1'b0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: fill the whole ID table first so no compare or poll ever
    // touches an unloaded entry. ID extremes at both table ends, a duplicate
    // pair at entries 3 and 5.
    for (int i = 0; i < DEVICES; i++) begin
      load_id = 16'($urandom_range(1, 16'hFFFE));
      if (i == 0)           load_id = 16'h0000;
      if (i == DEVICES - 1) load_id = 16'hFFFF;
      if (i == 3 || i == 5) load_id = 16'h5A5A;
      queue_cmd(pdlw_pkg::CMD_LOAD, load_id, 4'(i), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
    // zero count: first tick polls entry 0 without aging, second strands the
    // pointer above the count
    queue_cmd(pdlw_pkg::CMD_POLL, 16'h0000, 4'd0, 1'b0, 1'b1);
    queue_cmd(pdlw_pkg::CMD_POLL, 16'hFFFF, 4'd15, 1'b1, 1'b1);

    // count above the table depth saturates
    program_regs(5'd31, 1'b0);
    queue_cmd(pdlw_pkg::CMD_POLL,   16'h0000, 4'd0,  1'b0, 1'b0);  // disabled tick
    queue_cmd(pdlw_pkg::CMD_POLL,   16'h0000, 4'd0,  1'b0, 1'b1);
    queue_cmd(pdlw_pkg::CMD_POLL,   16'h0000, 4'd0,  1'b0, 1'b1);
    queue_cmd(pdlw_pkg::CMD_REPLY,  16'h5A5A, 4'd0,  1'b0, 1'b0);  // hits both duplicates
    queue_cmd(pdlw_pkg::CMD_REPLY,  16'h1234, 4'd0,  1'b0, 1'b0);  // unknown ID
    queue_cmd(pdlw_pkg::CMD_SWITCH, 16'h5A5A, 4'd0,  1'b1, 1'b0);
    queue_cmd(pdlw_pkg::CMD_SWITCH, 16'hFFFF, 4'd0,  1'b1, 1'b0);
    queue_cmd(pdlw_pkg::CMD_SWITCH, 16'h0000, 4'd0,  1'b0, 1'b0);

    // fixed-ten mode with ticks only drives entries 0..9 down to the floor
    run_phase(5'd16, 1'b1, 280, 1'b1);
    run_phase(5'd31, 1'b0, 110, 1'b0);
    run_phase(5'd2,  1'b0, 100, 1'b0);
    run_phase(5'd0,  1'b0, 60,  1'b0);
    run_phase(5'd10, 1'b1, 110, 1'b0);
    run_phase(5'd1,  1'b0, 100, 1'b0);
    run_phase(5'd17, 1'b0, 110, 1'b0);
    run_phase(5'd5,  1'b1, 90,  1'b0);
    run_phase(5'd11, 1'b0, 110, 1'b0);
    run_phase(5'd9,  1'b0, 90,  1'b0);
    run_phase(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 80, 1'b0);
    run_phase(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), 80, 1'b0);

    // drain, then let any trailing activity show itself
    do @(negedge clk_i); while (in_flight != 0 || pending_cmds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d command items, checked %0d status items over %0d register settings.",
             items_queued, results_seen, settings);
    $display("%0d polls issued; link counter floor %s.", polls_issued,
             floor_seen ? "reached" : "not reached");
    if (mismatches == 0 && expected_status.size() == 0 && results_seen == items_queued) begin
      $display("polled_device_link_watchdog verification clean");
    end else begin
      if (expected_status.size() != 0)
        $error("%0d expected results never arrived", expected_status.size());
      $display("polled_device_link_watchdog verification failed");
    end
    $finish;
  end

  // Watchdog on the whole run: several times the slowest legal run
  initial begin : timeout_proc
    #10_000_000;
    $display("polled_device_link_watchdog verification failed");
    $finish;
  end

endmodule
